// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by murmur_hash_64a
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising clk edge, muted while arst_n is low
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every rising clk edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/mh64_pkg.sv =====
// shared types and constants of the murmur 64a hasher
`default_nettype none
package mh64_pkg;

	localparam int unsigned WORD_W  = 64;
	localparam int unsigned HALF_W  = 32;
	localparam int unsigned BYTES_W = 4;
	localparam int unsigned LEN_W   = 32;
	localparam int unsigned MIX_SHIFT = 47;

	localparam logic [WORD_W-1:0] MIX_MUL = 64'hc6a4_a793_5bd1_e995;

	// request to the shared multiplier, product = operand * MIX_MUL mod 2^64
	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] operand;
	} mh64_mul_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [WORD_W-1:0] product;
	} mh64_mul_rsp_t;

	// x ^ (x >> 47)
	function automatic logic [WORD_W-1:0] xor_shift(input logic [WORD_W-1:0] x);
		return x ^ (x >> MIX_SHIFT);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mh64_if.sv =====
// valid/ready channel interfaces for message words and hash results
`default_nettype none
interface mh64_msg_if;
	import mh64_pkg::*;

	logic               valid;
	logic               ready;
	logic [WORD_W-1:0]  data_word;
	logic [BYTES_W-1:0] word_bytes;
	logic               first_word;
	logic               last_word;
	logic [LEN_W-1:0]   total_length;

	modport source (output valid, data_word, word_bytes, first_word, last_word,
		total_length, input ready);
	modport sink (input valid, data_word, word_bytes, first_word, last_word,
		total_length, output ready);
endinterface

interface mh64_hash_if;
	import mh64_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink (input valid, hash_value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mh64_mul.sv =====
// iterative 64x64 low-half multiplier by the mix constant, one 32x32 multiply per cycle
`default_nettype none
module mh64_mul (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mh64_pkg::mh64_mul_req_t req,
	output mh64_pkg::mh64_mul_rsp_t    rsp
);
	import mh64_pkg::*;

	localparam logic [1:0] STEP_LAST = 2'd3;

	logic              busy_q;
	logic              done_q;
	logic [1:0]        step_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] prod_s1;
	logic [HALF_W-1:0] mul_x;
	logic [HALF_W-1:0] mul_y;

	// partial products: lo*lo, lo*hi, hi*lo; hi*hi falls off the top
	always_comb begin
		case (step_q)
			2'd0: begin
				mul_x = a_q[HALF_W-1:0];
				mul_y = MIX_MUL[HALF_W-1:0];
			end
			2'd1: begin
				mul_x = a_q[HALF_W-1:0];
				mul_y = MIX_MUL[WORD_W-1:HALF_W];
			end
			default: begin
				mul_x = a_q[WORD_W-1:HALF_W];
				mul_y = MIX_MUL[HALF_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= busy_q && (step_q == STEP_LAST);
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == STEP_LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q)
			a_q <= req.operand;
		prod_s1 <= {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};
		if (busy_q) begin
			if (step_q == 2'd1)
				acc_q <= prod_s1;
			else if (step_q != 2'd0)
				acc_q <= acc_q + {prod_s1[HALF_W-1:0], {HALF_W{1'b0}}};
		end
	end

	assign rsp.busy    = busy_q;
	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule
`default_nettype wire

// ===== hw/rtl/murmur_hash_64a.sv =====
// murmur hash 64a top level: word sequencer around the shared multiplier
//
// channel   dir  beat contents
// msg       in   data_word, word_bytes, first_word, last_word, total_length
// hash      out  hash_value
// cfg       in   cfg_we / cfg_wdata write the seed, no read-back
//
// every 64-bit multiply is done in steps on the one 32x32 multiplier
// (issue, three partial products, final add, hand-back)
// a full word costs three multiplies, a tail word one,
// a first word adds one for the length term, a last word one for the avalanche
// msg.ready is high only while the sequencer is idle; a finished hash waits in
// the output register, so the next word is taken while the hash is unread
// reset clears the sequencer, the open-message flag, the seed and the output valid
`default_nettype none
module murmur_hash_64a (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [63:0]            cfg_wdata,
	mh64_msg_if.sink                    msg,
	mh64_hash_if.source                 hash
);
	import mh64_pkg::*;

	// sequencer codes
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INIT = 4'd1; // len * M
	localparam logic [3:0] S_DISP = 4'd2; // choose path by byte count
	localparam logic [3:0] S_MIXA = 4'd3; // k * M
	localparam logic [3:0] S_MIXB = 4'd4; // (k ^ k>>47) * M
	localparam logic [3:0] S_FOLD = 4'd5; // (h ^ k) * M
	localparam logic [3:0] S_TAIL = 4'd6; // (h ^ masked tail) * M
	localparam logic [3:0] S_AVAL = 4'd7; // (h ^ h>>47) * M
	localparam logic [3:0] S_FIN  = 4'd8; // last xor-shift into output register

	logic [3:0]         state_q;
	logic               issued_q;
	logic               in_msg_q;
	logic [WORD_W-1:0]  seed_q;
	logic [WORD_W-1:0]  h_q;
	logic [WORD_W-1:0]  k_q;
	logic [WORD_W-1:0]  word_q;
	logic [LEN_W-1:0]   len_q;
	logic [BYTES_W-1:0] nbytes_q;
	logic               last_q;
	logic               hash_vld_q;
	logic [WORD_W-1:0]  hash_q;

	logic               accept;
	logic               mul_state;
	logic               out_free;
	logic [WORD_W-1:0]  tail_mask;
	logic [BYTES_W-1:0] nbytes_in;
	mh64_mul_req_t      mul_req;
	mh64_mul_rsp_t      mul_rsp;

	assign msg.ready = (state_q == S_IDLE);
	assign accept    = msg.valid && msg.ready;

	// byte counts of eight and up mean a full word
	assign nbytes_in = msg.word_bytes[BYTES_W-1] ? BYTES_W'(8) : msg.word_bytes;

	// keep the low nbytes bytes of a tail word (1..7 here)
	assign tail_mask = ~({WORD_W{1'b1}} << {nbytes_q[2:0], 3'b000});

	assign mul_state = (state_q == S_INIT) || (state_q == S_MIXA) || (state_q == S_MIXB)
		|| (state_q == S_FOLD) || (state_q == S_TAIL) || (state_q == S_AVAL);

	// operand for the multiply of the current step
	always_comb begin
		mul_req.start = mul_state && !issued_q;
		case (state_q)
			S_INIT:  mul_req.operand = {{(WORD_W-LEN_W){1'b0}}, len_q};
			S_MIXA:  mul_req.operand = word_q;
			S_MIXB:  mul_req.operand = xor_shift(k_q);
			S_FOLD:  mul_req.operand = h_q ^ k_q;
			S_TAIL:  mul_req.operand = h_q ^ (word_q & tail_mask);
			default: mul_req.operand = xor_shift(h_q);
		endcase
	end

	mh64_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	assign out_free = !hash_vld_q || hash.ready;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			issued_q   <= 1'b0;
			in_msg_q   <= 1'b0;
			seed_q     <= '0;
			hash_vld_q <= 1'b0;
		end else begin
			if (cfg_we)
				seed_q <= cfg_wdata;
			// a new hash may replace one that leaves on this edge
			if ((state_q == S_FIN) && out_free)
				hash_vld_q <= 1'b1;
			else if (hash_vld_q && hash.ready)
				hash_vld_q <= 1'b0;
			if (mul_req.start)
				issued_q <= 1'b1;
			else if (mul_rsp.done)
				issued_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					// a word without first_word while no message is open is dropped
					if (accept && (msg.first_word || in_msg_q)) begin
						in_msg_q <= !msg.last_word;
						state_q  <= msg.first_word ? S_INIT : S_DISP;
					end
				end
				S_INIT: if (mul_rsp.done) state_q <= S_DISP;
				S_DISP: begin
					if (nbytes_q == BYTES_W'(8))
						state_q <= S_MIXA;
					else if (nbytes_q != '0)
						state_q <= S_TAIL;
					else
						state_q <= last_q ? S_AVAL : S_IDLE;
				end
				S_MIXA: if (mul_rsp.done) state_q <= S_MIXB;
				S_MIXB: if (mul_rsp.done) state_q <= S_FOLD;
				S_FOLD, S_TAIL: begin
					if (mul_rsp.done)
						state_q <= last_q ? S_AVAL : S_IDLE;
				end
				S_AVAL: if (mul_rsp.done) state_q <= S_FIN;
				S_FIN: begin
					// wait here while an older hash still sits unread
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			word_q   <= msg.data_word;
			nbytes_q <= nbytes_in;
			last_q   <= msg.last_word;
			len_q    <= msg.total_length;
		end
		if (mul_rsp.done) begin
			case (state_q)
				S_INIT:         h_q <= seed_q ^ mul_rsp.product;
				S_MIXA, S_MIXB: k_q <= mul_rsp.product;
				default:        h_q <= mul_rsp.product;
			endcase
		end
		if ((state_q == S_FIN) && out_free)
			hash_q <= xor_shift(h_q);
	end

	assign hash.valid      = hash_vld_q;
	assign hash.hash_value = hash_q;

`include "assert_macros.svh"

	// the multiplier only hands back a product to a step that asked for one
	`ASSERT_CLK(a_done_in_mul_state, mul_rsp.done |-> (mul_state && issued_q), "stray product")
	// a first word always starts with the length multiply
	`ASSERT_CLK(a_first_to_init, (accept && msg.first_word) |=> (state_q == S_INIT), "no init")
	// a finished hash is loaded whenever the output slot frees up
	`ASSERT_CLK(a_fin_loads, ((state_q == S_FIN) && out_free) |=> hash.valid, "hash not loaded")
	// no multiply is started while the unit is still working
	`ASSERT_CLK(a_no_overlap, !(mul_req.start && mul_rsp.busy), "multiplier overrun")

endmodule
`default_nettype wire
